// ----- design/sirs_pkg.sv -----
// Shared types, constants and the microcode program for signed_int_to_radix_symbols.
// No dependencies.
package sirs_pkg;

    localparam int MAX_BASE   = 16;
    localparam int SYM_W      = 8;
    localparam int NUM_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int MAX_DIGITS = 32;
    localparam int ND_W       = 6;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 64;

    localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'd43;
    localparam logic [SYM_W-1:0] MINUS_CHAR = 8'd45;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    // floor(2^32 / r) for r = 2..16, indexed by r[3:0]; r = 16 sits at index 0
    localparam logic [NUM_W-1:0] RECIP [MAX_BASE] = '{
        32'h1000_0000, 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
        32'h4000_0000, 32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924,
        32'h2000_0000, 32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174,
        32'h1555_5555, 32'h13B1_3B13, 32'h1249_2492, 32'h1111_1111
    };

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_CHECK   = 3'd1,
        OP_NOP     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIGIT   = 3'd4,
        OP_SIGN    = 3'd5,
        OP_EMIT    = 3'd6,
        OP_INVALID = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_IDLE       = 3'd2,
        C_SCAN       = 3'd3,
        C_OK         = 3'd4,
        C_MORE       = 3'd5,
        C_DIGIT_LEFT = 3'd6
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MUL   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd7;

    // Branch to target when cond holds, else next step; the last step wraps to idle.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            3'd0:    w = '{OP_LOAD,    C_IDLE,       STEP_IDLE};
            3'd1:    w = '{OP_CHECK,   C_SCAN,       STEP_SCAN};
            3'd2:    w = '{OP_NOP,     C_OK,         STEP_MUL};
            3'd3:    w = '{OP_INVALID, C_ALWAYS,     STEP_IDLE};
            3'd4:    w = '{OP_MUL,     C_NEVER,      STEP_IDLE};
            3'd5:    w = '{OP_DIGIT,   C_MORE,       STEP_MUL};
            3'd6:    w = '{OP_SIGN,    C_NEVER,      STEP_IDLE};
            3'd7:    w = '{OP_EMIT,    C_DIGIT_LEFT, STEP_EMIT};
            default: w = '{OP_NOP,     C_ALWAYS,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- design/signed_int_to_radix_symbols_top.sv -----
// Signed integer to radix symbol converter, microcoded sequencer and datapath; uses sirs_pkg.
// Busy through an alphabet scan over all sixteen symbol slots and a check step; for a valid
// alphabet then a multiply step through the reciprocal multiplier and a digit step per digit,
// a sign step and an emit step per symbol. Results then come one per cycle, no stall.
// A new start is accepted only while busy is low.
// Reset clears the sequencer, result strobe and config registers; datapath loads before use.
module signed_int_to_radix_symbols_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [sirs_pkg::NUM_W-1:0] number,
    input  logic                             cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sirs_pkg::CFG_W-1:0]       cfg_data,
    output logic                             result_valid,
    output logic [sirs_pkg::SYM_W-1:0]       symbol,
    output logic                             last,
    output logic                             invalid_base
);

    logic [sirs_pkg::STEP_W-1:0]   pc_reg, pc_next;
    logic [sirs_pkg::RADIX_W-1:0]  base_size_reg;
    logic [sirs_pkg::CFG_W-1:0]    symbols_low_reg, symbols_high_reg;
    logic [3:0]                    scan_reg, scan_next;
    logic                          bad_reg, bad_next;
    logic                          neg_reg, neg_next;
    logic [sirs_pkg::NUM_W-1:0]    mag_reg, mag_next;
    logic [sirs_pkg::NUM_W-1:0]    qest_reg, qest_next;
    logic [sirs_pkg::ND_W-1:0]     nd_reg, nd_next;
    logic [sirs_pkg::DIGIT_W-1:0]  digit_reg [sirs_pkg::MAX_DIGITS];
    logic                          result_valid_reg, result_valid_next;
    logic [sirs_pkg::SYM_W-1:0]    symbol_reg, symbol_next;
    logic                          last_reg, last_next;
    logic                          invalid_reg, invalid_next;

    sirs_pkg::ctrl_word_t          cw;
    logic                          taken;
    logic [sirs_pkg::SYM_W-1:0]    sym_all [sirs_pkg::MAX_BASE];
    logic [sirs_pkg::SYM_W-1:0]    scan_sym;
    logic                          scan_bad;
    logic [63:0]                   prod;
    logic [36:0]                   qr;
    logic [36:0]                   rem_wide;
    logic [sirs_pkg::RADIX_W-1:0]  rem;
    logic                          rem_ge;
    logic [sirs_pkg::DIGIT_W-1:0]  digit_val;
    logic [sirs_pkg::NUM_W-1:0]    q_fix;
    logic [4:0]                    emit_idx;
    logic                          digit_we;

    assign busy         = (pc_reg != sirs_pkg::STEP_IDLE);
    assign result_valid = result_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign invalid_base = invalid_reg;

    assign cw = sirs_pkg::ucode(pc_reg);

    always_comb
    begin
        for (int k = 0; k < sirs_pkg::MAX_BASE / 2; k++)
        begin
            sym_all[k]     = symbols_low_reg[8*k +: 8];
            sym_all[k + 8] = symbols_high_reg[8*k +: 8];
        end
    end

    // alphabet scan: symbol scan_reg against sign characters and all later symbols in use
    always_comb
    begin
        scan_sym = sym_all[scan_reg];
        scan_bad = (scan_sym == sirs_pkg::PLUS_CHAR) || (scan_sym == sirs_pkg::MINUS_CHAR);
        for (int b = 0; b < sirs_pkg::MAX_BASE; b++)
        begin
            if ((4'(b) > scan_reg) && (5'(b) < base_size_reg) && (sym_all[b] == scan_sym))
            begin
                scan_bad = 1'b1;
            end
        end
        if ({1'b0, scan_reg} >= base_size_reg)
        begin
            scan_bad = 1'b0;
        end
    end

    // digit extraction: quotient estimate is q or q-1, one correction step
    assign prod      = 64'(mag_reg) * 64'(sirs_pkg::RECIP[base_size_reg[3:0]]);
    assign qr        = 37'(qest_reg) * 37'(base_size_reg);
    assign rem_wide  = {5'b0, mag_reg} - qr;
    assign rem       = rem_wide[4:0];
    assign rem_ge    = (rem >= base_size_reg);
    assign digit_val = rem_ge ? 4'(rem - base_size_reg) : rem[3:0];
    assign q_fix     = qest_reg + 32'(rem_ge);
    assign emit_idx  = 5'(nd_reg - 6'd1);

    always_comb
    begin
        case (cw.cond)
            sirs_pkg::C_NEVER:      taken = 1'b0;
            sirs_pkg::C_ALWAYS:     taken = 1'b1;
            sirs_pkg::C_IDLE:       taken = !start;
            sirs_pkg::C_SCAN:       taken = (scan_reg != 4'hF);
            sirs_pkg::C_OK:         taken = !bad_reg;
            sirs_pkg::C_MORE:       taken = (q_fix != '0);
            sirs_pkg::C_DIGIT_LEFT: taken = (nd_reg != 6'd1);
            default:                taken = 1'b0;
        endcase
        pc_next = taken ? cw.target : pc_reg + 3'd1;
    end

    always_comb
    begin
        scan_next         = scan_reg;
        bad_next          = bad_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        qest_next         = qest_reg;
        nd_next           = nd_reg;
        digit_we          = 1'b0;
        result_valid_next = 1'b0;
        symbol_next       = symbol_reg;
        last_next         = last_reg;
        invalid_next      = invalid_reg;
        unique case (cw.op)
            sirs_pkg::OP_LOAD:
            begin
                neg_next  = number[sirs_pkg::NUM_W-1];
                mag_next  = number[sirs_pkg::NUM_W-1] ? 32'd0 - 32'(number) : 32'(number);
                nd_next   = '0;
                scan_next = '0;
                bad_next  = (base_size_reg < 5'd2) || (base_size_reg > 5'(sirs_pkg::MAX_BASE));
            end
            sirs_pkg::OP_CHECK:
            begin
                scan_next = scan_reg + 4'd1;
                bad_next  = bad_reg | scan_bad;
            end
            sirs_pkg::OP_NOP:
            begin
            end
            sirs_pkg::OP_MUL:
            begin
                qest_next = prod[63:32];
            end
            sirs_pkg::OP_DIGIT:
            begin
                digit_we = 1'b1;
                mag_next = q_fix;
                nd_next  = nd_reg + 6'd1;
            end
            sirs_pkg::OP_SIGN:
            begin
                result_valid_next = neg_reg;
                symbol_next       = sirs_pkg::MINUS_CHAR;
                last_next         = 1'b0;
                invalid_next      = 1'b0;
            end
            sirs_pkg::OP_EMIT:
            begin
                result_valid_next = 1'b1;
                symbol_next       = sym_all[digit_reg[emit_idx]];
                last_next         = (nd_reg == 6'd1);
                invalid_next      = 1'b0;
                nd_next           = nd_reg - 6'd1;
            end
            sirs_pkg::OP_INVALID:
            begin
                result_valid_next = 1'b1;
                symbol_next       = '0;
                last_next         = 1'b1;
                invalid_next      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= sirs_pkg::STEP_IDLE;
            result_valid_reg <= 1'b0;
            base_size_reg    <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else
        begin
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sirs_pkg::REG_BASE_SIZE:    base_size_reg    <= cfg_data[4:0];
                    sirs_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                    sirs_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        bad_reg     <= bad_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        qest_reg    <= qest_next;
        nd_reg      <= nd_next;
        symbol_reg  <= symbol_next;
        last_reg    <= last_next;
        invalid_reg <= invalid_next;
        if (digit_we)
        begin
            digit_reg[nd_reg[4:0]] <= digit_val;
        end
    end

endmodule

// ----- sim/sirs_symbol_checker.sv -----
// Scoreboard for signed_int_to_radix_symbols: tracks register writes, predicts the symbol
// stream of every accepted transaction and compares it with the result port.
// Depends on sirs_pkg.
module sirs_symbol_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [sirs_pkg::NUM_W-1:0]        number,
    input  logic                              cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sirs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              result_valid,
    input  logic [sirs_pkg::SYM_W-1:0]        symbol,
    input  logic                              last,
    input  logic                              invalid_base,
    output int                                errors,
    output int                                backlog
);

    typedef struct packed {
        logic [sirs_pkg::SYM_W-1:0] sym;
        logic                       last;
        logic                       inv;
    } glyph_t;

    glyph_t                       expected_glyphs[$];
    logic [sirs_pkg::RADIX_W-1:0] radix_reg = '0;
    logic [sirs_pkg::CFG_W-1:0]   low_syms  = '0;
    logic [sirs_pkg::CFG_W-1:0]   high_syms = '0;
    int                           mismatches = 0;

    function automatic logic [sirs_pkg::SYM_W-1:0] glyph_of(int k);
        logic [sirs_pkg::CFG_W-1:0] word;
        word = (k < 8) ? low_syms : high_syms;
        return word[8*(k%8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        logic [sirs_pkg::SYM_W-1:0] s;
        if (radix_reg < 2 || radix_reg > sirs_pkg::MAX_BASE)
            return 1'b0;
        for (int a = 0; a < radix_reg; a++)
        begin
            s = glyph_of(a);
            if (s == sirs_pkg::PLUS_CHAR || s == sirs_pkg::MINUS_CHAR)
                return 1'b0;
            for (int b = a + 1; b < radix_reg; b++)
                if (glyph_of(b) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_conversion(logic [sirs_pkg::NUM_W-1:0] value);
        logic [sirs_pkg::NUM_W-1:0]   mag;
        logic [sirs_pkg::DIGIT_W-1:0] digits [sirs_pkg::MAX_DIGITS];
        int                           nd;
        if (!alphabet_valid())
        begin
            expected_glyphs.push_back('{8'd0, 1'b1, 1'b1});
            return;
        end
        mag = value[sirs_pkg::NUM_W-1] ? -value : value;
        nd = 0;
        // least significant digit first; zero still gives one digit
        do
        begin
            digits[nd] = sirs_pkg::DIGIT_W'(mag % sirs_pkg::NUM_W'(radix_reg));
            mag = mag / sirs_pkg::NUM_W'(radix_reg);
            nd++;
        end
        while (mag != 0 && nd < sirs_pkg::MAX_DIGITS);
        if (value[sirs_pkg::NUM_W-1])
            expected_glyphs.push_back('{sirs_pkg::MINUS_CHAR, 1'b0, 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            expected_glyphs.push_back('{glyph_of(digits[i]), i == 0, 1'b0});
    endfunction

    always @(posedge clk)
    begin
        glyph_t want;
        if (!rst_n)
        begin
            radix_reg = '0;
            low_syms  = '0;
            high_syms = '0;
            expected_glyphs.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    $error("unexpected result: symbol %0d last %0b invalid_base %0b",
                           symbol, last, invalid_base);
                    mismatches++;
                end
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (symbol !== want.sym)
                    begin
                        $error("symbol: expected %0d, got %0d", want.sym, symbol);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches++;
                    end
                    if (invalid_base !== want.inv)
                    begin
                        $error("invalid_base: expected %0b, got %0b", want.inv, invalid_base);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                predict_conversion(number);
            if (cfg_we)
            begin
                case (cfg_index)
                    sirs_pkg::REG_BASE_SIZE:    radix_reg = cfg_data[sirs_pkg::RADIX_W-1:0];
                    sirs_pkg::REG_SYMBOLS_LOW:  low_syms  = cfg_data;
                    sirs_pkg::REG_SYMBOLS_HIGH: high_syms = cfg_data;
                    default: ;
                endcase
            end
        end
        errors  <= mismatches;
        backlog <= expected_glyphs.size();
    end

endmodule

// ----- sim/signed_int_to_radix_symbols_top_test.sv -----
// Testbench top for signed_int_to_radix_symbols: clock, reset, alphabet setup, directed
// number transactions and random ones in bursts; checking is done by sirs_symbol_checker.
// Depends on sirs_pkg, signed_int_to_radix_symbols_top and sirs_symbol_checker.
module signed_int_to_radix_symbols_top_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {FAULT_DUP, FAULT_PLUS, FAULT_MINUS} fault_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              start     = 1'b0;
    logic signed [sirs_pkg::NUM_W-1:0] number    = '0;
    logic                              cfg_we    = 1'b0;
    logic [sirs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [sirs_pkg::CFG_W-1:0]        cfg_data  = '0;
    logic                              busy;
    logic                              result_valid;
    logic [sirs_pkg::SYM_W-1:0]        symbol;
    logic                              last;
    logic                              invalid_base;
    int                                errors;
    int                                backlog;
    int                                cycles = 0;

    signed_int_to_radix_symbols_top DUT (.*);

    sirs_symbol_checker checker_i (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [sirs_pkg::CFG_IDX_W-1:0] idx,
                             logic [sirs_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_alphabet(int radix, logic [sirs_pkg::CFG_W-1:0] lo,
                                 logic [sirs_pkg::CFG_W-1:0] hi);
        write_reg(sirs_pkg::REG_BASE_SIZE, sirs_pkg::CFG_W'(radix));
        write_reg(sirs_pkg::REG_SYMBOLS_LOW, lo);
        write_reg(sirs_pkg::REG_SYMBOLS_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic convert(logic [sirs_pkg::NUM_W-1:0] value);
        start  <= 1'b1;
        number <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (backlog != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [sirs_pkg::NUM_W-1:0] random_number();
        logic [sirs_pkg::NUM_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -$urandom_range(1, 40);
            3:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '1;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic random_phase(int radix, bit broken, int count);
        logic [sirs_pkg::SYM_W-1:0] sy [sirs_pkg::MAX_BASE];
        bit [255:0]                 taken;
        logic [sirs_pkg::CFG_W-1:0] lo;
        logic [sirs_pkg::CFG_W-1:0] hi;
        logic [sirs_pkg::SYM_W-1:0] pick;
        fault_t                     fault;
        int                         i;
        int                         j;
        int                         burst;
        bit                         steady;
        taken = '0;
        for (int k = 0; k < sirs_pkg::MAX_BASE; k++)
        begin
            if (k < radix)
            begin
                do
                    pick = sirs_pkg::SYM_W'($urandom_range(0, 255));
                while (pick == sirs_pkg::PLUS_CHAR || pick == sirs_pkg::MINUS_CHAR ||
                       taken[pick]);
                taken[pick] = 1'b1;
                sy[k] = pick;
            end
            else
                sy[k] = sirs_pkg::SYM_W'($urandom_range(0, 255));
        end
        if (broken && radix >= 2)
        begin
            i = $urandom_range(0, radix - 1);
            fault = fault_t'($urandom_range(0, 2));
            case (fault)
                FAULT_DUP:
                begin
                    j = $urandom_range(0, radix - 1);
                    if (j == i)
                        j = (i + 1) % radix;
                    sy[j] = sy[i];
                end
                FAULT_PLUS: sy[i] = sirs_pkg::PLUS_CHAR;
                default:    sy[i] = sirs_pkg::MINUS_CHAR;
            endcase
        end
        for (int k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = sy[k];
            hi[8*k +: 8] = sy[k+8];
        end
        load_alphabet(radix, lo, hi);
        steady = ($urandom_range(0, 3) == 0);
        burst = $urandom_range(1, 10);
        repeat (count)
        begin
            if (!steady && burst <= 0)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (busy)
                    @(posedge clk);
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst = $urandom_range(1, 10);
            end
            convert(random_number());
            burst--;
        end
        drain();
    endtask

    initial
    begin
        int radix;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alphabet left empty by reset
        convert(-5);
        drain();

        load_alphabet(10, 64'h3736_3534_3332_3130, 64'h3938);
        convert(0);
        convert(-1);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0000);
        convert(10);
        drain();

        load_alphabet(2, 64'h3130, '0);
        convert(32'h8000_0000);
        convert(32'h7FFF_FFFF);
        convert(0);
        drain();

        load_alphabet(16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
        convert('1);
        convert(32'hDEAD_BEEF);
        convert(32'h8000_0000);
        drain();

        load_alphabet(1, 64'h30, '0);
        convert(1);
        drain();

        load_alphabet(4, 64'h3331_3130, '0);
        convert(12);
        drain();

        load_alphabet(3, 64'h2B_3130, '0);
        convert(7);
        drain();

        load_alphabet(3, 64'h2D_3130, '0);
        convert(7);
        drain();

        // zero byte in use; signs and repeats only above the radix
        load_alphabet(3, 64'h0000_002D_2BFF_0100, '1);
        convert(0);
        convert(-8);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                radix = 2;
            else if (p == 1)
                radix = sirs_pkg::MAX_BASE;
            else
                radix = $urandom_range(2, sirs_pkg::MAX_BASE);
            random_phase(radix, p >= 2 && $urandom_range(0, 4) == 0, 12);
        end
        random_phase($urandom_range(0, 1), 1'b1, 5);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && backlog == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
